@@ rtl/afs_pkg.sv @@
// Shared types, register indexes and widths for the animation frame sequencer.
package afs_pkg;

    // Default sizes handed down as top-level parameters
    localparam int FRAME_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 40;

    // Fixed field widths
    localparam int FRAME_COUNT_W  = 13;
    localparam int PERIOD_W       = 20;
    localparam int CYCLE_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_AFTER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 2'd3;

    // Item function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_PAUSE = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CMP,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

@@ rtl/afs_alu.sv @@
// Shared adder/subtractor used by the accumulate, end-of-cycle compare and division steps of the sequencer.
module afs_alu #(
    parameter int W = 41
) (
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  afs_pkg::t_alu_op i_op,
    output logic [W-1:0]     o_y,
    output logic             o_carry
);

    logic [W-1:0] w_b;
    logic         w_cin;

    // Subtract as a + ~b + 1; carry out high means a >= b
    assign w_b   = (i_op == afs_pkg::ALU_SUB) ? ~i_b : i_b;
    assign w_cin = (i_op == afs_pkg::ALU_SUB);
    assign {o_carry, o_y} = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, w_cin};

endmodule

@@ rtl/afs_core.sv @@
// Sequencer and state registers: accumulate, end-of-cycle check, frame division.
module afs_core #(
    parameter int FRAME_BITS = afs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = afs_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_func,
    input  logic [afs_pkg::PERIOD_W-1:0]  i_elapsed,
    input  logic                          i_pause_value,
    input  logic [FRAME_BITS:0]           i_count,
    input  logic [afs_pkg::PERIOD_W-1:0]  i_period,
    input  logic [afs_pkg::CYCLE_W-1:0]   i_pause_after,
    input  logic                          i_reverse,
    input  logic                          i_hold,
    output logic                          o_idle,
    output logic                          o_done,
    output logic [FRAME_BITS-1:0]         o_frame,
    output logic                          o_paused,
    output logic [afs_pkg::CYCLE_W-1:0]   o_cycle
);

    localparam int CNT_W  = FRAME_BITS + 1;
    localparam int LIM_W  = afs_pkg::PERIOD_W + CNT_W;
    localparam int W      = ((TIME_BITS > LIM_W) ? TIME_BITS : LIM_W) + 1;
    localparam int STEP_W = $clog2(FRAME_BITS + 1);

    afs_pkg::t_state r_state, n_state;

    logic [TIME_BITS-1:0]         r_time, n_time;
    logic [afs_pkg::CYCLE_W-1:0]  r_cycle, n_cycle;
    logic [FRAME_BITS-1:0]        r_held, n_held;
    logic                         r_paused, n_paused;
    logic [afs_pkg::PERIOD_W-1:0] r_elapsed, n_elapsed;
    logic [LIM_W-1:0]             r_limit, n_limit;
    logic [W-1:0]                 r_rem, n_rem;
    logic [W-1:0]                 r_dsh, n_dsh;
    logic [FRAME_BITS-1:0]        r_quo, n_quo;
    logic [STEP_W-1:0]            r_step, n_step;

    logic [W-1:0]     w_a, w_b, w_y;
    logic             w_carry;
    afs_pkg::t_alu_op w_op;
    logic [FRAME_BITS-1:0] w_quo;
    logic [CNT_W-1:0]      w_idx;
    logic [CNT_W-1:0]      w_last;

    afs_alu #(.W(W)) u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_op    (w_op),
        .o_y     (w_y),
        .o_carry (w_carry)
    );

    assign w_quo  = (r_quo << 1) | FRAME_BITS'(w_carry);
    assign w_last = i_count - CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_time    = r_time;
        n_cycle   = r_cycle;
        n_held    = r_held;
        n_paused  = r_paused;
        n_elapsed = r_elapsed;
        n_limit   = r_limit;
        n_rem     = r_rem;
        n_dsh     = r_dsh;
        n_quo     = r_quo;
        n_step    = r_step;
        w_a       = W'(r_time);
        w_b       = W'(r_elapsed);
        w_op      = afs_pkg::ALU_ADD;
        w_idx     = {1'b0, w_quo};
        o_done    = 1'b0;
        case (r_state)
            afs_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_func == afs_pkg::FUNC_PAUSE) begin
                        n_paused = i_pause_value;
                        n_state  = afs_pkg::ST_FIN;
                    end else if (r_paused) begin
                        n_state = afs_pkg::ST_FIN;
                    end else begin
                        n_elapsed = i_elapsed;
                        n_state   = afs_pkg::ST_ADD;
                    end
                end
            end
            afs_pkg::ST_ADD: begin
                // saturating accumulate; cycle limit taken from the multiplier
                if (|w_y[W-1:TIME_BITS]) begin
                    n_time = '1;
                end else begin
                    n_time = w_y[TIME_BITS-1:0];
                end
                n_limit = LIM_W'(i_count) * LIM_W'(i_period);
                n_state = afs_pkg::ST_CMP;
            end
            afs_pkg::ST_CMP: begin
                w_b  = W'(r_limit);
                w_op = afs_pkg::ALU_SUB;
                if (w_carry) begin
                    // cycle complete: drop overshoot, advance or self-pause
                    n_time = '0;
                    n_rem  = '0;
                    if (i_pause_after == r_cycle) begin
                        n_paused = 1'b1;
                        n_cycle  = afs_pkg::CYCLE_W'(1);
                    end else begin
                        n_cycle = r_cycle + afs_pkg::CYCLE_W'(1);
                    end
                end else begin
                    n_rem = W'(r_time);
                end
                n_dsh   = W'(i_period) << (FRAME_BITS - 1);
                n_quo   = '0;
                n_step  = STEP_W'(FRAME_BITS - 1);
                n_state = afs_pkg::ST_DIV;
            end
            afs_pkg::ST_DIV: begin
                // one quotient bit per cycle, restoring division
                w_a  = r_rem;
                w_b  = r_dsh;
                w_op = afs_pkg::ALU_SUB;
                if (w_carry) begin
                    n_rem = w_y;
                end
                n_quo = w_quo;
                n_dsh = r_dsh >> 1;
                if (r_step == '0) begin
                    if (w_idx >= i_count) begin
                        w_idx = w_last;
                    end
                    if (i_reverse) begin
                        w_idx = w_last - w_idx;
                    end
                    n_held  = w_idx[FRAME_BITS-1:0];
                    n_state = afs_pkg::ST_FIN;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            afs_pkg::ST_FIN: begin
                if (!i_hold) begin
                    o_done  = 1'b1;
                    n_state = afs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = afs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= afs_pkg::ST_IDLE;
            r_time   <= '0;
            r_cycle  <= afs_pkg::CYCLE_W'(1);
            r_held   <= '0;
            r_paused <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_time   <= n_time;
            r_cycle  <= n_cycle;
            r_held   <= n_held;
            r_paused <= n_paused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_limit   <= n_limit;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_quo     <= n_quo;
        r_step    <= n_step;
    end

    assign o_idle   = (r_state == afs_pkg::ST_IDLE);
    assign o_frame  = r_held;
    assign o_paused = r_paused;
    assign o_cycle  = r_cycle;

endmodule

@@ rtl/animation_frame_sequencer.sv @@
// Top level of the animation frame sequencer: configuration, sequencer and result register.
// Usage:
//   Input channel (i_in_valid / o_in_ready): i_func selects a time tick (i_elapsed ticks
//   join the cycle-time accumulator) or a write of the paused flag (i_pause_value).
//   Every item yields one result (o_out_valid / i_out_ready): held frame index,
//   paused flag and animation cycle number after that item. Configuration port
//   (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is always ready; write it
//   only while no item is in flight.
// Sequence:
//   Unpaused tick: from acceptance to the result register it goes through
//   accumulate and limit multiply, end-of-cycle compare, FRAME_BITS restoring
//   divider steps on the shared adder, result load. Pause write or paused tick:
//   straight to result load. o_in_ready returns at the edge that loads the result,
//   so a new item is accepted only once the previous one has left the sequencer.
// Reset and stalls:
//   Synchronous active-low reset clears the accumulator, sets the cycle number
//   to 1, the held frame to 0, unpauses, and loads register defaults. A stalled
//   receiver holds the result register; the next item may still be accepted,
//   and its result waits in the sequencer until the register frees up.
module animation_frame_sequencer #(
    parameter int FRAME_BITS = afs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = afs_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [afs_pkg::PERIOD_W-1:0]    i_elapsed,
    input  logic                            i_pause_value,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [FRAME_BITS-1:0]           o_frame_index,
    output logic                            o_is_paused,
    output logic [afs_pkg::CYCLE_W-1:0]     o_cycle_number
);

    localparam int CNT_W = FRAME_BITS + 1;
    localparam int EXT_W = (afs_pkg::FRAME_COUNT_W > CNT_W) ? afs_pkg::FRAME_COUNT_W : CNT_W;

    // Configuration registers
    logic [afs_pkg::FRAME_COUNT_W-1:0] r_frame_count;
    logic [afs_pkg::PERIOD_W-1:0]      r_frame_period;
    logic [afs_pkg::CYCLE_W-1:0]       r_pause_after;
    logic                              r_reverse;

    // Result register
    logic                              r_out_valid;
    logic [FRAME_BITS-1:0]             r_out_frame;
    logic                              r_out_paused;
    logic [afs_pkg::CYCLE_W-1:0]       r_out_cycle;

    logic [EXT_W-1:0]                  w_count_ext;
    logic [EXT_W-1:0]                  w_count_max;
    logic [CNT_W-1:0]                  w_count;
    logic [afs_pkg::PERIOD_W-1:0]      w_period;
    logic                              w_idle;
    logic                              w_done;
    logic                              w_hold;
    logic [FRAME_BITS-1:0]             w_frame;
    logic                              w_paused;
    logic [afs_pkg::CYCLE_W-1:0]       w_cycle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= afs_pkg::FRAME_COUNT_W'(1);
            r_frame_period <= afs_pkg::PERIOD_W'(1);
            r_pause_after  <= '0;
            r_reverse      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                afs_pkg::CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[afs_pkg::FRAME_COUNT_W-1:0];
                afs_pkg::CFG_FRAME_PERIOD: r_frame_period <= i_cfg_data[afs_pkg::PERIOD_W-1:0];
                afs_pkg::CFG_PAUSE_AFTER:  r_pause_after  <= i_cfg_data[afs_pkg::CYCLE_W-1:0];
                afs_pkg::CFG_REVERSE:      r_reverse      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective frame count: zero reads as one, clamp to the frame index range
    assign w_count_ext = EXT_W'(r_frame_count);
    assign w_count_max = EXT_W'(1) << FRAME_BITS;

    always_comb begin
        if (w_count_ext == '0) begin
            w_count = CNT_W'(1);
        end else if (w_count_ext > w_count_max) begin
            w_count = w_count_max[CNT_W-1:0];
        end else begin
            w_count = w_count_ext[CNT_W-1:0];
        end
    end

    // Effective period: zero reads as one
    assign w_period = (r_frame_period == '0) ? afs_pkg::PERIOD_W'(1) : r_frame_period;

    // Hold the sequencer's result while the output register is still occupied
    assign w_hold     = r_out_valid && !i_out_ready;
    assign o_in_ready = w_idle;

    afs_core #(
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in_valid && o_in_ready),
        .i_func        (i_func),
        .i_elapsed     (i_elapsed),
        .i_pause_value (i_pause_value),
        .i_count       (w_count),
        .i_period      (w_period),
        .i_pause_after (r_pause_after),
        .i_reverse     (r_reverse),
        .i_hold        (w_hold),
        .o_idle        (w_idle),
        .o_done        (w_done),
        .o_frame       (w_frame),
        .o_paused      (w_paused),
        .o_cycle       (w_cycle)
    );

    // Result register: load on completion, drop valid once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_frame  <= w_frame;
            r_out_paused <= w_paused;
            r_out_cycle  <= w_cycle;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_index  = r_out_frame;
    assign o_is_paused    = r_out_paused;
    assign o_cycle_number = r_out_cycle;

endmodule
